### hw/rtl/rgbhsv_pkg.sv
// Shared widths, types and the divider word layout for the RGB to HSV converter.
package rgbhsv_pkg;

	localparam int CHAN_W          = 8;
	localparam int HUE_W           = 16;
	localparam int SAT_W           = 16;
	localparam int QUO_W           = 16;
	// Widest divisor is six times the largest chroma, 6 * 255 = 1530.
	localparam int DVS_W           = 11;
	localparam int REM_SH_W        = DVS_W + 1;
	localparam int STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES      = QUO_W / STEPS_PER_STAGE;

	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	// One restoring-division lane: partial remainder, divisor, numerator bits
	// still to be shifted in, and the quotient built so far.
	typedef struct packed {
		logic [DVS_W-1:0] rem;
		logic [DVS_W-1:0] dvs;
		logic [QUO_W-1:0] num_lo;
		logic [QUO_W-1:0] quo;
	} div_lane_t;

	typedef struct packed {
		logic [CHAN_W-1:0] brightness;
		logic              hue_zero;
		logic              sat_zero;
	} side_t;

	typedef struct packed {
		div_lane_t hue;
		div_lane_t sat;
		side_t     side;
	} div_word_t;

endpackage

### hw/rtl/rgbhsv_div.sv
// Pipelined two-lane restoring divider that retires two quotient bits per stage.
module rgbhsv_div
	import rgbhsv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  div_word_t in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output div_word_t out_word
);

	function automatic div_lane_t div_step(input div_lane_t l);
		div_lane_t           o;
		logic [REM_SH_W-1:0] rem_sh;
		logic [REM_SH_W:0]   diff;
		o      = l;
		rem_sh = {l.rem, l.num_lo[QUO_W-1]};
		diff   = {1'b0, rem_sh} - {2'b00, l.dvs};
		o.num_lo = {l.num_lo[QUO_W-2:0], 1'b0};
		if (!diff[REM_SH_W]) begin
			o.rem = diff[DVS_W-1:0];
			o.quo = {l.quo[QUO_W-2:0], 1'b1};
		end else begin
			o.rem = rem_sh[DVS_W-1:0];
			o.quo = {l.quo[QUO_W-2:0], 1'b0};
		end
		return o;
	endfunction

	function automatic div_word_t word_step(input div_word_t w);
		div_word_t o;
		o = w;
		for (int i = 0; i < STEPS_PER_STAGE; i++) begin
			o.hue = div_step(o.hue);
			o.sat = div_step(o.sat);
		end
		return o;
	endfunction

	div_word_t             word_s [DIV_STAGES];
	logic [DIV_STAGES-1:0] vld_s;
	div_word_t             word_in [DIV_STAGES];
	logic [DIV_STAGES-1:0] vld_in;
	logic [DIV_STAGES:0]   rdy;

	// A stage may load when it is empty or its contents move on this cycle.
	always_comb begin
		rdy[DIV_STAGES] = out_ready;
		for (int k = DIV_STAGES - 1; k >= 0; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	always_comb begin
		vld_in[0]  = in_valid;
		word_in[0] = in_word;
		for (int k = 1; k < DIV_STAGES; k++) begin
			vld_in[k]  = vld_s[k-1];
			word_in[k] = word_s[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= vld_in[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (rdy[k] && vld_in[k]) begin
				word_s[k] <= word_step(word_in[k]);
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[DIV_STAGES-1];
	assign out_word  = word_s[DIV_STAGES-1];

endmodule

### hw/rtl/rgb_to_hsv_pixel_converter_top.sv
// Top level of the RGB to HSV pixel converter pipeline.
//
// The converter takes one 8-bit RGB word per clock and returns hue (a 16-bit
// fraction of a full turn), saturation (chroma over value scaled by 65535,
// truncated) and brightness (the largest channel). It sustains one word per
// cycle while the output is not stalled. Each word passes eleven register
// stages: one stage finds the maximum, minimum and hue sector, one stage
// forms the hue and saturation numerators and divisors, eight stages of a
// pipelined restoring divider each retire two quotient bits for both
// quotients, and a final output register clears hue for gray pixels and
// saturation for black ones. Every stage has its own valid bit and loads
// whenever it is empty or its word moves on, so bubbles close up and a
// stalled output only holds the pipeline once all stages are full. No state
// is kept between words.

module rgb_to_hsv_pixel_converter_top
	import rgbhsv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pixel_valid,
	output logic              pixel_ready,
	input  logic [CHAN_W-1:0] red,
	input  logic [CHAN_W-1:0] green,
	input  logic [CHAN_W-1:0] blue,
	output logic              hsv_valid,
	input  logic              hsv_ready,
	output logic [HUE_W-1:0]  hue,
	output logic [SAT_W-1:0]  saturation,
	output logic [CHAN_W-1:0] brightness
);

	// Stage 1: maximum, minimum, sector and the signed channel difference.
	// On a tied maximum red wins over green, and green wins over blue.
	sector_t                  sect_c;
	logic [CHAN_W-1:0]        val_c;
	logic [CHAN_W-1:0]        min_c;
	logic signed [CHAN_W:0]   diff_c;

	always_comb begin
		if (red >= green && red >= blue) begin
			sect_c = SECT_RED;
			val_c  = red;
			diff_c = $signed({1'b0, green}) - $signed({1'b0, blue});
		end else if (green >= blue) begin
			sect_c = SECT_GREEN;
			val_c  = green;
			diff_c = $signed({1'b0, blue}) - $signed({1'b0, red});
		end else begin
			sect_c = SECT_BLUE;
			val_c  = blue;
			diff_c = $signed({1'b0, red}) - $signed({1'b0, green});
		end
		if (red <= green && red <= blue) begin
			min_c = red;
		end else if (green <= blue) begin
			min_c = green;
		end else begin
			min_c = blue;
		end
	end

	logic                   vld_s1;
	sector_t                sect_s1;
	logic [CHAN_W-1:0]      val_s1;
	logic [CHAN_W-1:0]      chroma_s1;
	logic signed [CHAN_W:0] diff_s1;
	logic                   rdy_s1;
	logic                   rdy_s2;
	logic                   vld_s2;
	div_word_t              word_s2;
	logic                   div_in_ready;
	logic                   div_out_valid;
	div_word_t              div_out_word;
	logic                   out_rdy;

	// Backpressure travels stage by stage, so an empty stage always loads.
	assign out_rdy     = !hsv_valid || hsv_ready;
	assign rdy_s2      = !vld_s2 || div_in_ready;
	assign rdy_s1      = !vld_s1 || rdy_s2;
	assign pixel_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && pixel_valid) begin
			sect_s1   <= sect_c;
			val_s1    <= val_c;
			chroma_s1 <= val_c - min_c;
			diff_s1   <= diff_c;
		end
	end

	// Stage 2: hue numerator n = offset*C + d, wrapped by 6*C when negative,
	// over the divisor 6*C; saturation numerator C*65535 over the value.
	logic [DVS_W-1:0]        six_c;
	logic [DVS_W-1:0]        offset_c;
	logic signed [DVS_W:0]   n_raw;
	logic signed [DVS_W:0]   n_wrap;
	logic [CHAN_W+QUO_W-1:0] sat_num;
	div_word_t               word_c;

	always_comb begin
		six_c = {{(DVS_W-CHAN_W-2){1'b0}}, chroma_s1, 2'b00}
			+ {{(DVS_W-CHAN_W-1){1'b0}}, chroma_s1, 1'b0};
		case (sect_s1)
			SECT_RED:   offset_c = '0;
			SECT_GREEN: offset_c = {{(DVS_W-CHAN_W-1){1'b0}}, chroma_s1, 1'b0};
			SECT_BLUE:  offset_c = {{(DVS_W-CHAN_W-2){1'b0}}, chroma_s1, 2'b00};
			default:    offset_c = '0;
		endcase
		n_raw = $signed({1'b0, offset_c})
			+ {{(DVS_W-CHAN_W){diff_s1[CHAN_W]}}, diff_s1};
		if (n_raw < 0) begin
			n_wrap = n_raw + $signed({1'b0, six_c});
		end else begin
			n_wrap = n_raw;
		end
		sat_num = {chroma_s1, {QUO_W{1'b0}}} - {{QUO_W{1'b0}}, chroma_s1};

		word_c.hue.rem     = n_wrap[DVS_W-1:0];
		word_c.hue.dvs     = six_c;
		word_c.hue.num_lo  = '0;
		word_c.hue.quo     = '0;
		word_c.sat.rem     = {{(DVS_W-CHAN_W){1'b0}}, sat_num[CHAN_W+QUO_W-1:QUO_W]};
		word_c.sat.dvs     = {{(DVS_W-CHAN_W){1'b0}}, val_s1};
		word_c.sat.num_lo  = sat_num[QUO_W-1:0];
		word_c.sat.quo     = '0;
		word_c.side.brightness = val_s1;
		word_c.side.hue_zero   = (chroma_s1 == '0);
		word_c.side.sat_zero   = (val_s1 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			word_s2 <= word_c;
		end
	end

	// Stages 3 to 10: both divisions advance side by side.
	rgbhsv_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_ready  (div_in_ready),
		.in_word   (word_s2),
		.out_valid (div_out_valid),
		.out_ready (out_rdy),
		.out_word  (div_out_word)
	);

	// Output register: a gray pixel has hue zero and a black pixel has
	// saturation zero, whatever the divider produced for a zero divisor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsv_valid <= 1'b0;
		end else if (out_rdy) begin
			hsv_valid <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && div_out_valid) begin
			hue        <= div_out_word.side.hue_zero ? '0 : div_out_word.hue.quo;
			saturation <= div_out_word.side.sat_zero ? '0 : div_out_word.sat.quo;
			brightness <= div_out_word.side.brightness;
		end
	end

	// A drained output means every stage is free to take a word.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!hsv_valid |-> pixel_ready)
		else $error("converter refused a word with an empty output");

	// The wrapped hue numerator must be below its divisor, or the quotient
	// would overflow sixteen bits.
	a_hue_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !word_s2.side.hue_zero |-> word_s2.hue.rem < word_s2.hue.dvs)
		else $error("hue numerator outside one turn");

	a_sat_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !word_s2.side.sat_zero |-> word_s2.sat.rem < word_s2.sat.dvs)
		else $error("saturation numerator exceeds value");

	a_black_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && brightness == '0 |-> hue == '0 && saturation == '0)
		else $error("black pixel with nonzero hue or saturation");

	a_zero_sat_zero_hue: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && saturation == '0 |-> hue == '0)
		else $error("gray pixel with nonzero hue");

endmodule
